>>> design/lprd_pkg.sv
// Shared types and constants for the length-prefixed response deframer.
package lprd_pkg;

	localparam int CFG_W     = 24;
	localparam int BLOCK_W   = 16;
	localparam int MSGLEN_W  = 32;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CFG_W-1:0] MAX_LEN_RESET = 24'hFFFFFF;
	localparam logic [BLOCK_W-1:0] BLOCK_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_FIRST_DIGIT = 3'd0,
		PH_LENGTH      = 3'd1,
		PH_DATA        = 3'd2,
		PH_DATA_NL     = 3'd3,
		PH_NEXT        = 3'd4,
		PH_DONE        = 3'd5,
		PH_ERROR       = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_INCOMPLETE = 2'd0,
		ST_COMPLETE   = 2'd1,
		ST_MALFORMED  = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_t;

	typedef struct packed {
		status_t              frame_status;
		logic [MSGLEN_W-1:0]  message_length;
		logic [BLOCK_W-1:0]   block_count;
	} out_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

endpackage

>>> design/lprd_step.sv
// Next-state and result logic for one byte of the response parse.
module lprd_step #(
	parameter int LENGTH_BITS  = 24,
	parameter int MESSAGE_BITS = 32
) (
	input  lprd_pkg::in_t                  item,
	input  logic [lprd_pkg::CFG_W-1:0]     max_len,
	input  lprd_pkg::phase_t               phase,
	input  logic [LENGTH_BITS-1:0]         acc,
	input  logic [LENGTH_BITS-1:0]         rem,
	input  logic [MESSAGE_BITS-1:0]        cnt,
	input  logic [lprd_pkg::BLOCK_W-1:0]   blk,
	output lprd_pkg::phase_t               phase_n,
	output logic [LENGTH_BITS-1:0]         acc_n,
	output logic [LENGTH_BITS-1:0]         rem_n,
	output logic [MESSAGE_BITS-1:0]        cnt_n,
	output logic [lprd_pkg::BLOCK_W-1:0]   blk_n,
	output lprd_pkg::out_t                 result
);

	localparam int NB = ((LENGTH_BITS > lprd_pkg::CFG_W) ? LENGTH_BITS : lprd_pkg::CFG_W) + 4;

	lprd_pkg::phase_t ph;
	logic [LENGTH_BITS-1:0] acc_e;
	logic [LENGTH_BITS-1:0] rem_e;
	logic [MESSAGE_BITS-1:0] cnt_e;
	logic [lprd_pkg::BLOCK_W-1:0] blk_e;
	logic [3:0] dig;
	logic digit;
	logic [NB-1:0] acc_w;
	logic [NB-1:0] next_w;
	logic [NB-1:0] max_w;
	logic first_ok;
	logic acc_ok;
	logic bad;
	lprd_pkg::status_t status;
	logic [MESSAGE_BITS+31:0] cnt_wide;

	// A first byte restarts the parse from the cleared state.
	assign ph    = item.first_byte ? lprd_pkg::PH_FIRST_DIGIT : phase;
	assign acc_e = item.first_byte ? '0 : acc;
	assign rem_e = item.first_byte ? '0 : rem;
	assign cnt_e = item.first_byte ? '0 : cnt;
	assign blk_e = item.first_byte ? '0 : blk;

	assign digit  = lprd_pkg::is_digit(item.data_byte);
	assign dig    = item.data_byte[3:0];
	assign acc_w  = {{(NB-LENGTH_BITS){1'b0}}, acc_e};
	assign next_w = (acc_w << 3) + (acc_w << 1) + {{(NB-4){1'b0}}, dig};
	assign max_w  = {{(NB-lprd_pkg::CFG_W){1'b0}}, max_len};

	assign first_ok = digit && ({{(lprd_pkg::CFG_W-4){1'b0}}, dig} <= max_len);
	assign acc_ok   = digit && (next_w <= max_w) && (next_w[NB-1:LENGTH_BITS] == '0);

	always_comb begin
		bad     = 1'b0;
		status  = lprd_pkg::ST_INCOMPLETE;
		phase_n = ph;
		acc_n   = acc_e;
		rem_n   = rem_e;
		cnt_n   = cnt_e;
		blk_n   = blk_e;
		if (ph == lprd_pkg::PH_ERROR || ph == lprd_pkg::PH_DONE) begin
			bad = 1'b1;
		end else if (&cnt_e) begin
			bad = 1'b1;
		end else begin
			cnt_n = cnt_e + {{(MESSAGE_BITS-1){1'b0}}, 1'b1};
			unique case (ph)
				lprd_pkg::PH_FIRST_DIGIT: begin
					acc_n = {{(LENGTH_BITS-4){1'b0}}, dig};
					if (first_ok)
						phase_n = lprd_pkg::PH_LENGTH;
					else
						bad = 1'b1;
				end
				lprd_pkg::PH_LENGTH: begin
					if (item.data_byte == lprd_pkg::NEWLINE_CHAR) begin
						rem_n   = acc_e;
						phase_n = (acc_e == '0) ? lprd_pkg::PH_DATA_NL : lprd_pkg::PH_DATA;
					end else if (acc_ok) begin
						acc_n = next_w[LENGTH_BITS-1:0];
					end else begin
						bad = 1'b1;
					end
				end
				lprd_pkg::PH_DATA: begin
					rem_n = rem_e - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
					if (rem_e == {{(LENGTH_BITS-1){1'b0}}, 1'b1})
						phase_n = lprd_pkg::PH_DATA_NL;
				end
				lprd_pkg::PH_DATA_NL: begin
					if (item.data_byte == lprd_pkg::NEWLINE_CHAR) begin
						if (blk_e != lprd_pkg::BLOCK_MAX)
							blk_n = blk_e + {{(lprd_pkg::BLOCK_W-1){1'b0}}, 1'b1};
						phase_n = lprd_pkg::PH_NEXT;
					end else begin
						bad = 1'b1;
					end
				end
				lprd_pkg::PH_NEXT: begin
					if (item.data_byte == lprd_pkg::NEWLINE_CHAR) begin
						phase_n = lprd_pkg::PH_DONE;
						status  = lprd_pkg::ST_COMPLETE;
					end else begin
						acc_n = {{(LENGTH_BITS-4){1'b0}}, dig};
						if (first_ok)
							phase_n = lprd_pkg::PH_LENGTH;
						else
							bad = 1'b1;
					end
				end
				default: begin
					bad = 1'b1;
				end
			endcase
		end
		if (bad) begin
			phase_n = lprd_pkg::PH_ERROR;
			status  = lprd_pkg::ST_MALFORMED;
		end
	end

	assign cnt_wide = {32'b0, cnt_n};

	assign result.frame_status   = status;
	assign result.message_length = (status == lprd_pkg::ST_COMPLETE) ? cnt_wide[31:0] : '0;
	assign result.block_count    = blk_n;

endmodule

>>> design/length_prefixed_response_deframer_core.sv
// Top level of the length-prefixed response deframer: input stage, parse state and result register.
//
// Response bytes enter on the item channel (valid/ready), one transaction per byte, with
// first_byte marking the start of a new response. Every byte produces exactly one result
// transaction on the result channel: incomplete, complete (with total length including the
// final newline and the block count) or malformed. Malformed holds until the next first byte.
// The cfg channel writes the largest accepted block length; it is always ready and is meant
// to be written only while no bytes are in flight.
// An accepted byte is held in the input stage; its result is registered in the result register
// once that register is free, and result_valid rises with it.
// Throughput: one byte per cycle while the result register is free, set by the combinational step
// from input stage to result register, which also updates the parse state.
// Reset: clears both stages, sets the maximum block length to 16777215 and puts the parser
// at the first length digit, so the first byte after reset starts a response.
// When the receiver stalls, the result register holds, one further byte waits in the input
// stage, and item_ready then drops until the result is taken.
module length_prefixed_response_deframer_core #(
	parameter int LENGTH_BITS  = 24,
	parameter int MESSAGE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  lprd_pkg::in_t                 item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output lprd_pkg::out_t                result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lprd_pkg::CFG_W-1:0]    cfg_data
);

	lprd_pkg::in_t item_s1;
	logic valid_s1;
	logic advance;
	logic [lprd_pkg::CFG_W-1:0] max_len_q;
	lprd_pkg::phase_t phase_q;
	logic [LENGTH_BITS-1:0] acc_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [MESSAGE_BITS-1:0] cnt_q;
	logic [lprd_pkg::BLOCK_W-1:0] blk_q;
	lprd_pkg::phase_t phase_n;
	logic [LENGTH_BITS-1:0] acc_n;
	logic [LENGTH_BITS-1:0] rem_n;
	logic [MESSAGE_BITS-1:0] cnt_n;
	logic [lprd_pkg::BLOCK_W-1:0] blk_n;
	lprd_pkg::out_t step_result;
	lprd_pkg::out_t result_q;
	logic result_valid_q;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;

	lprd_step #(
		.LENGTH_BITS  (LENGTH_BITS),
		.MESSAGE_BITS (MESSAGE_BITS)
	) u_step (
		.item    (item_s1),
		.max_len (max_len_q),
		.phase   (phase_q),
		.acc     (acc_q),
		.rem     (rem_q),
		.cnt     (cnt_q),
		.blk     (blk_q),
		.phase_n (phase_n),
		.acc_n   (acc_n),
		.rem_n   (rem_n),
		.cnt_n   (cnt_n),
		.blk_n   (blk_n),
		.result  (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lprd_pkg::MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lprd_pkg::PH_FIRST_DIGIT;
			acc_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			blk_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			rem_q   <= rem_n;
			cnt_q   <= cnt_n;
			blk_q   <= blk_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= step_result;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// An empty result register never holds back the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> item_ready)
		else $error("input stalled with an empty result register");

	// A completed response has seen at least one block.
	a_complete_has_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.frame_status == lprd_pkg::ST_COMPLETE
		|-> result_q.block_count != '0)
		else $error("complete response reported without any block");

	// The length field is zero unless the response is complete.
	a_length_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.frame_status != lprd_pkg::ST_COMPLETE
		|-> result_q.message_length == '0)
		else $error("message length set on an incomplete or malformed result");

	// After completion or an error, a byte without restart is malformed.
	a_sticky_error: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item_s1.first_byte
		&& (phase_q == lprd_pkg::PH_ERROR || phase_q == lprd_pkg::PH_DONE)
		|=> result_q.frame_status == lprd_pkg::ST_MALFORMED)
		else $error("byte after completion or error not flagged malformed");

endmodule

>>> test/tb_length_prefixed_response_deframer_core.sv
// Self-checking testbench for the length-prefixed response deframer core.
`timescale 1ns / 100ps

module tb_length_prefixed_response_deframer_core;

	localparam int DECIMAL_BASE = 10;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_BYTES  = 175;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	lprd_pkg::in_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	lprd_pkg::out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lprd_pkg::CFG_W-1:0] cfg_data = '0;

	lprd_pkg::in_t pend_q[$];
	lprd_pkg::out_t want_q[$];
	int fail_cnt = 0;

	int burst_left = 0;
	int gap_left = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int seg_left = 0;
	int seg_mode = 0;

	logic [lprd_pkg::CFG_W-1:0] max_len_shadow = lprd_pkg::MAX_LEN_RESET;
	lprd_pkg::phase_t ph = lprd_pkg::PH_FIRST_DIGIT;
	logic [23:0] len_acc = '0;
	logic [23:0] data_left = '0;
	logic [31:0] byte_total = '0;
	logic [15:0] blk_seen = '0;

	length_prefixed_response_deframer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit accum_digit(input logic [7:0] b, input logic [23:0] acc,
			input logic [23:0] lim, output logic [23:0] nacc);
		logic [63:0] n;
		nacc = acc;
		if (b < 8'h30 || b > 8'h39)
			return 1'b0;
		n = 64'(acc) * DECIMAL_BASE + 64'(b - 8'h30);
		if (n > 64'(lim))
			return 1'b0;
		nacc = n[23:0];
		return 1'b1;
	endfunction

	task automatic deframe_step(input lprd_pkg::in_t it);
		lprd_pkg::out_t o;
		logic bad;
		logic [7:0] b;
		b = it.data_byte;
		bad = 1'b0;
		o.frame_status = lprd_pkg::ST_INCOMPLETE;
		if (it.first_byte) begin
			ph = lprd_pkg::PH_FIRST_DIGIT;
			len_acc = '0;
			data_left = '0;
			byte_total = '0;
			blk_seen = '0;
		end
		if (ph == lprd_pkg::PH_ERROR || ph == lprd_pkg::PH_DONE) begin
			bad = 1'b1;
		end else if (byte_total == 32'hFFFF_FFFF) begin
			bad = 1'b1;
		end else begin
			byte_total = byte_total + 1;
			case (ph)
				lprd_pkg::PH_FIRST_DIGIT: begin
					len_acc = '0;
					if (accum_digit(b, len_acc, max_len_shadow, len_acc))
						ph = lprd_pkg::PH_LENGTH;
					else
						bad = 1'b1;
				end
				lprd_pkg::PH_LENGTH: begin
					if (b == lprd_pkg::NEWLINE_CHAR) begin
						data_left = len_acc;
						ph = (data_left == 0) ? lprd_pkg::PH_DATA_NL : lprd_pkg::PH_DATA;
					end else if (!accum_digit(b, len_acc, max_len_shadow, len_acc)) begin
						bad = 1'b1;
					end
				end
				lprd_pkg::PH_DATA: begin
					data_left = data_left - 1;
					if (data_left == 0)
						ph = lprd_pkg::PH_DATA_NL;
				end
				lprd_pkg::PH_DATA_NL: begin
					if (b == lprd_pkg::NEWLINE_CHAR) begin
						if (blk_seen != lprd_pkg::BLOCK_MAX)
							blk_seen = blk_seen + 1;
						ph = lprd_pkg::PH_NEXT;
					end else begin
						bad = 1'b1;
					end
				end
				lprd_pkg::PH_NEXT: begin
					if (b == lprd_pkg::NEWLINE_CHAR) begin
						ph = lprd_pkg::PH_DONE;
						o.frame_status = lprd_pkg::ST_COMPLETE;
					end else begin
						len_acc = '0;
						if (accum_digit(b, len_acc, max_len_shadow, len_acc))
							ph = lprd_pkg::PH_LENGTH;
						else
							bad = 1'b1;
					end
				end
				default: bad = 1'b1;
			endcase
		end
		if (bad) begin
			ph = lprd_pkg::PH_ERROR;
			o.frame_status = lprd_pkg::ST_MALFORMED;
		end
		o.message_length = (o.frame_status == lprd_pkg::ST_COMPLETE) ? byte_total : '0;
		o.block_count = blk_seen;
		want_q = {want_q, o};
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (item_valid && item_ready)
			deframe_step(item);
		if (!item_valid || item_ready) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				item_valid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				item <= pend_q.pop_front();
				item_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: segments of free flow, random stalls and sparse acceptance, plus a long hold-off.
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				seg_mode <= $urandom_range(0, 2);
				seg_left <= $urandom_range(8, 60);
			end else begin
				seg_left <= seg_left - 1;
			end
			case (seg_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= 1'($urandom_range(0, 1));
				default: result_ready <= (seg_left[1:0] == 2'd0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			max_len_shadow <= cfg_data;
	end

	always @(posedge clk) begin
		lprd_pkg::out_t w;
		if (result_valid && result_ready) begin
			if (want_q.size() == 0) begin
				$error("result transaction with no expectation pending");
				fail_cnt++;
			end else begin
				w = want_q.pop_front();
				if (result.frame_status !== w.frame_status) begin
					$error("frame_status expected %0d actual %0d", w.frame_status,
						result.frame_status);
					fail_cnt++;
				end
				if (result.message_length !== w.message_length) begin
					$error("message_length expected %0d actual %0d", w.message_length,
						result.message_length);
					fail_cnt++;
				end
				if (result.block_count !== w.block_count) begin
					$error("block_count expected %0d actual %0d", w.block_count,
						result.block_count);
					fail_cnt++;
				end
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic fb);
		lprd_pkg::in_t x;
		x.data_byte = b;
		x.first_byte = fb;
		pend_q = {pend_q, x};
	endtask

	task automatic push_str(input string s, input logic fb);
		foreach (s[i])
			push_byte(s[i], (i == 0) ? fb : 1'b0);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pend_q.size() != 0 || item_valid || want_q.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [lprd_pkg::CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_response(input logic [lprd_pkg::CFG_W-1:0] lim);
		logic [7:0] bytes[$];
		logic [7:0] nl;
		int nblk;
		int len;
		int cap;
		string digits;
		logic fb;
		nl = lprd_pkg::NEWLINE_CHAR;
		if ($urandom_range(0, 11) == 0) begin
			len = $urandom_range(1, 6);
			repeat (len) bytes = {bytes, 8'($urandom_range(0, 255))};
			fb = 1'($urandom_range(0, 1));
		end else begin
			nblk = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
			cap = (lim < 10) ? int'(lim) : 10;
			for (int k = 0; k < nblk; k++) begin
				if ($urandom_range(0, 14) == 0) begin
					digits = $sformatf("%0d", int'(lim) + 1);
					foreach (digits[i]) bytes = {bytes, 8'(digits[i])};
					break;
				end
				len = $urandom_range(0, cap);
				if ($urandom_range(0, 5) == 0)
					digits = $sformatf("0%0d", len);
				else
					digits = $sformatf("%0d", len);
				foreach (digits[i]) bytes = {bytes, 8'(digits[i])};
				bytes = {bytes, nl};
				repeat (len) bytes = {bytes, 8'($urandom_range(0, 255))};
				bytes = {bytes, nl};
			end
			bytes = {bytes, nl};
			case ($urandom_range(0, 9))
				0: bytes[$urandom_range(0, bytes.size() - 1)] = 8'($urandom_range(0, 255));
				1: begin
					if (bytes.size() > 1)
						repeat ($urandom_range(1, bytes.size() - 1)) void'(bytes.pop_back());
				end
				2: bytes = {bytes, 8'($urandom_range(0, 255))};
				default: ;
			endcase
			fb = ($urandom_range(0, 9) != 0);
		end
		foreach (bytes[i])
			push_byte(bytes[i], (i == 0) ? fb : 1'b0);
	endtask

	initial begin
		logic [lprd_pkg::CFG_W-1:0] settings[6];
		int start_size;
		int queued;
		settings[0] = lprd_pkg::MAX_LEN_RESET;
		settings[1] = '0;
		settings[2] = 24'd5;
		settings[3] = 24'($urandom_range(1, 30));
		settings[4] = 24'd12;
		settings[5] = lprd_pkg::MAX_LEN_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// After reset the first byte starts a response even without first_byte.
		push_str("1\n", 1'b0);
		push_byte(8'hFF, 1'b0);
		push_str("\n\n", 1'b0);
		push_byte("z", 1'b0);
		push_str("0\n\n\n", 1'b1);
		push_byte(lprd_pkg::NEWLINE_CHAR, 1'b1);
		push_byte(8'h00, 1'b0);
		push_str("+", 1'b1);
		push_str(" ", 1'b1);
		push_str("01\n", 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte("A", 1'b0);
		push_str("16777216", 1'b1);
		push_str("2", 1'b1);
		push_str("1\n", 1'b1);
		wait_drained();

		foreach (settings[p]) begin
			if (p > 0) begin
				wait_drained();
				write_max_len(settings[p]);
				@(negedge clk);
			end
			if (p == 2) begin
				@(posedge clk);
				hold_req <= hold_req + 1;
				@(negedge clk);
			end
			queued = 0;
			while (queued < PHASE_BYTES) begin
				start_size = pend_q.size();
				queue_response(settings[p]);
				queued += pend_q.size() - start_size;
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (want_q.size() != 0) begin
			$error("%0d expected results never arrived", want_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("[length_prefixed_response_deframer_core] OK");
		else
			$display("[length_prefixed_response_deframer_core] ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[length_prefixed_response_deframer_core] ERROR");
		$finish;
	end

endmodule
